// File: hw/rtl/sjf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sjf_pkg;

   localparam int MAX_PROCS = 16;
   localparam int TIME_BITS = 16;
   localparam int IDX_BITS  = $clog2(MAX_PROCS);
   localparam int CNT_BITS  = $clog2(MAX_PROCS + 1);
   // worst finish time: every burst at full scale after the latest arrival
   localparam int CLK_BITS  = TIME_BITS + CNT_BITS;
   localparam int TOT_BITS  = 24;
   localparam int RAM_BITS  = 2 * TIME_BITS;

   localparam logic [TOT_BITS-1:0] TOT_MAX = '1;

   typedef struct packed {
      logic [15:0] burst_time;
      logic [15:0] arrival_time;
      logic        last_process;
   } req_type;

   typedef struct packed {
      logic [3:0]  process_index;
      logic [19:0] waiting_time;
      logic [19:0] turnaround_time;
      logic [20:0] completion_time;
      logic [23:0] total_waiting;
      logic [23:0] total_turnaround;
      logic        overflow_flag;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] burst;
      logic [TIME_BITS-1:0] arrival;
   } sjf_entry_type;

   // winner of one scan over the store
   typedef struct packed {
      logic                 valid;
      logic [IDX_BITS-1:0]  idx;
      logic [TIME_BITS-1:0] burst;
      logic [TIME_BITS-1:0] arrival;
      logic [CLK_BITS-1:0]  start;
   } sjf_choice_type;

endpackage

`default_nettype wire

// File: hw/rtl/sjf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sjf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: hw/rtl/sjf_pick.sv
`timescale 1ns / 1ps
`default_nettype none

module sjf_pick
   import sjf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                clear,
   input  wire logic                entry_valid,
   input  wire sjf_entry_type       entry,
   input  wire logic [IDX_BITS-1:0] entry_idx,
   input  wire logic                entry_done,
   input  wire logic [CLK_BITS-1:0] sched_clock,
   output sjf_choice_type           choice
);

   // best among arrived processes: shortest burst, then earliest arrival
   logic                 rdy_found_ff, rdy_found_in;
   logic [IDX_BITS-1:0]  rdy_idx_ff, rdy_idx_in;
   logic [TIME_BITS-1:0] rdy_burst_ff, rdy_burst_in;
   logic [TIME_BITS-1:0] rdy_arr_ff, rdy_arr_in;
   // best among pending: earliest arrival, then shortest burst
   logic                 pnd_found_ff, pnd_found_in;
   logic [IDX_BITS-1:0]  pnd_idx_ff, pnd_idx_in;
   logic [TIME_BITS-1:0] pnd_burst_ff, pnd_burst_in;
   logic [TIME_BITS-1:0] pnd_arr_ff, pnd_arr_in;

   logic arrived;
   logic rdy_better;
   logic pnd_better;

   always_comb begin
      arrived    = CLK_BITS'(entry.arrival) <= sched_clock;
      rdy_better = !rdy_found_ff || (entry.burst < rdy_burst_ff) ||
                   ((entry.burst == rdy_burst_ff) && (entry.arrival < rdy_arr_ff));
      pnd_better = !pnd_found_ff || (entry.arrival < pnd_arr_ff) ||
                   ((entry.arrival == pnd_arr_ff) && (entry.burst < pnd_burst_ff));

      rdy_found_in = rdy_found_ff;
      rdy_idx_in   = rdy_idx_ff;
      rdy_burst_in = rdy_burst_ff;
      rdy_arr_in   = rdy_arr_ff;
      pnd_found_in = pnd_found_ff;
      pnd_idx_in   = pnd_idx_ff;
      pnd_burst_in = pnd_burst_ff;
      pnd_arr_in   = pnd_arr_ff;

      if (clear) begin
         rdy_found_in = 1'b0;
         pnd_found_in = 1'b0;
      end else if (entry_valid && !entry_done) begin
         // strict compares keep the lower index on a full tie
         if (arrived && rdy_better) begin
            rdy_found_in = 1'b1;
            rdy_idx_in   = entry_idx;
            rdy_burst_in = entry.burst;
            rdy_arr_in   = entry.arrival;
         end
         if (pnd_better) begin
            pnd_found_in = 1'b1;
            pnd_idx_in   = entry_idx;
            pnd_burst_in = entry.burst;
            pnd_arr_in   = entry.arrival;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rdy_found_ff <= 1'b0;
         pnd_found_ff <= 1'b0;
      end else begin
         rdy_found_ff <= rdy_found_in;
         pnd_found_ff <= pnd_found_in;
      end
      rdy_idx_ff   <= rdy_idx_in;
      rdy_burst_ff <= rdy_burst_in;
      rdy_arr_ff   <= rdy_arr_in;
      pnd_idx_ff   <= pnd_idx_in;
      pnd_burst_ff <= pnd_burst_in;
      pnd_arr_ff   <= pnd_arr_in;
   end

   // nothing arrived yet: the clock jumps to the earliest pending arrival
   always_comb begin
      choice.valid = rdy_found_ff || pnd_found_ff;
      if (rdy_found_ff) begin
         choice.idx     = rdy_idx_ff;
         choice.burst   = rdy_burst_ff;
         choice.arrival = rdy_arr_ff;
         choice.start   = sched_clock;
      end else begin
         choice.idx     = pnd_idx_ff;
         choice.burst   = pnd_burst_ff;
         choice.arrival = pnd_arr_ff;
         choice.start   = CLK_BITS'(pnd_arr_ff);
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/sjf_nonpreemptive_scheduler_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Non-preemptive shortest-job-first scheduler.
// req channel: one process record (burst, arrival, last flag) per transaction,
// numbered in load order. Records are taken one per cycle while loading; a
// record beyond the 16-entry store is dropped and sets overflow_flag on the
// results of that set.
// The record marked last starts scheduling and req_stall goes high until the
// final result of the run is in the output register. Each pick scans the store
// once through the shared compare unit, one entry per cycle through the
// registered-read store.
// rsp channel: one transaction per process in run order; the last one carries
// last_result and the totals. A stalled rsp holds its payload and the
// sequencer waits; the output register frees the store for the next pick.
// Reset (synchronous, active high) empties the store and returns to loading.
// After the final result is written the block is loading the next set.
module sjf_nonpreemptive_scheduler_top
   import sjf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]  pos_ff, pos_in;
   logic [CNT_BITS-1:0]  res_cnt_ff, res_cnt_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [IDX_BITS-1:0]  rd_idx_ff, rd_idx_in;
   logic [MAX_PROCS-1:0] done_ff, done_in;
   logic [CLK_BITS-1:0]  clock_ff, clock_in;
   logic                 ovf_ff, ovf_in;
   logic [TOT_BITS-1:0]  tot_w_ff, tot_w_in;
   logic [TOT_BITS-1:0]  tot_t_ff, tot_t_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 req_go;
   logic                 full;
   logic                 issue;
   logic                 emit_go;
   logic                 is_last;
   logic [CLK_BITS-1:0]  fin;
   logic [CLK_BITS-1:0]  wait_t;
   logic [CLK_BITS-1:0]  turn_t;
   logic [TOT_BITS:0]    tw_sum;
   logic [TOT_BITS:0]    tt_sum;
   logic [TOT_BITS-1:0]  tw_sat;
   logic [TOT_BITS-1:0]  tt_sat;

   sjf_entry_type        wr_entry;
   logic [RAM_BITS-1:0]  rd_word;
   sjf_entry_type        rd_entry;
   sjf_choice_type       choice;

   assign req_stall = (state_ff != ST_LOAD);
   assign req_go    = req_valid && !req_stall;
   assign full      = (cnt_ff == CNT_BITS'(MAX_PROCS));
   assign issue     = (state_ff == ST_SCAN) && (pos_ff < cnt_ff);
   assign emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign is_last   = ((res_cnt_ff + CNT_BITS'(1)) == cnt_ff);

   assign wr_entry.burst   = TIME_BITS'(req_data.burst_time);
   assign wr_entry.arrival = TIME_BITS'(req_data.arrival_time);
   assign rd_entry         = sjf_entry_type'(rd_word);

   sjf_ram #(
      .WIDTH (RAM_BITS),
      .DEPTH (MAX_PROCS)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_go && !full),
      .wr_addr (cnt_ff[IDX_BITS-1:0]),
      .wr_data (RAM_BITS'(wr_entry)),
      .rd_addr (pos_ff[IDX_BITS-1:0]),
      .rd_data (rd_word)
   );

   sjf_pick u_pick (
      .clock       (clock),
      .reset       (reset),
      .clear       (emit_go),
      .entry_valid (rd_vld_ff),
      .entry       (rd_entry),
      .entry_idx   (rd_idx_ff),
      .entry_done  (done_ff[rd_idx_ff]),
      .sched_clock (clock_ff),
      .choice      (choice)
   );

   // result arithmetic for the chosen process
   always_comb begin
      fin    = choice.start + CLK_BITS'(choice.burst);
      wait_t = choice.start - CLK_BITS'(choice.arrival);
      turn_t = fin - CLK_BITS'(choice.arrival);
      tw_sum = {1'b0, tot_w_ff} + (TOT_BITS + 1)'(wait_t);
      tt_sum = {1'b0, tot_t_ff} + (TOT_BITS + 1)'(turn_t);
      tw_sat = tw_sum[TOT_BITS] ? TOT_MAX : tw_sum[TOT_BITS-1:0];
      tt_sat = tt_sum[TOT_BITS] ? TOT_MAX : tt_sum[TOT_BITS-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      res_cnt_in   = res_cnt_ff;
      rd_vld_in    = issue;
      rd_idx_in    = pos_ff[IDX_BITS-1:0];
      done_in      = done_ff;
      clock_in     = clock_ff;
      ovf_in       = ovf_ff;
      tot_w_in     = tot_w_ff;
      tot_t_in     = tot_t_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_LOAD: begin
            if (req_go) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  cnt_in = cnt_ff + CNT_BITS'(1);
               end
               if (req_data.last_process) begin
                  state_in   = ST_SCAN;
                  pos_in     = '0;
                  res_cnt_in = '0;
                  clock_in   = '0;
                  tot_w_in   = '0;
                  tot_t_in   = '0;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               pos_in = pos_ff + CNT_BITS'(1);
            end else if (!rd_vld_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.process_index    = 4'(choice.idx);
               rsp_data_in.waiting_time     = 20'(wait_t);
               rsp_data_in.turnaround_time  = 20'(turn_t);
               rsp_data_in.completion_time  = 21'(fin);
               rsp_data_in.total_waiting    = is_last ? 24'(tw_sat) : '0;
               rsp_data_in.total_turnaround = is_last ? 24'(tt_sat) : '0;
               rsp_data_in.overflow_flag    = ovf_ff;
               rsp_data_in.last_result      = is_last;
               if (is_last) begin
                  state_in = ST_LOAD;
                  cnt_in   = '0;
                  done_in  = '0;
                  clock_in = '0;
                  ovf_in   = 1'b0;
               end else begin
                  state_in   = ST_SCAN;
                  pos_in     = '0;
                  res_cnt_in = res_cnt_ff + CNT_BITS'(1);
                  done_in[choice.idx] = 1'b1;
                  clock_in   = fin;
                  tot_w_in   = tw_sat;
                  tot_t_in   = tt_sat;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         res_cnt_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         done_ff      <= '0;
         clock_ff     <= '0;
         ovf_ff       <= 1'b0;
         tot_w_ff     <= '0;
         tot_t_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         res_cnt_ff   <= res_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         done_ff      <= done_in;
         clock_ff     <= clock_in;
         ovf_ff       <= ovf_in;
         tot_w_ff     <= tot_w_in;
         tot_t_ff     <= tot_t_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff   <= rd_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // the store never holds more records than it has entries
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(MAX_PROCS))
      else $error("loaded count above store depth");

   // a pick always names a process that has not run yet in this set
   a_pick_fresh: assert property (@(posedge clock) disable iff (reset)
      emit_go |-> (choice.valid && !done_ff[choice.idx]))
      else $error("scheduled process missing or already done");

   // results of a run never outnumber the loaded records
   a_res_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> (res_cnt_ff < cnt_ff))
      else $error("result count reached loaded count");

   // the final result of a run reopens loading on the next cycle
   a_reopen: assert property (@(posedge clock) disable iff (reset)
      (emit_go && is_last) |=> (!req_stall && rsp_valid && rsp_data.last_result))
      else $error("loading not reopened after the final result");

endmodule

`default_nettype wire

// File: dv/sjf_schedule_monitor.sv
`timescale 1ns / 1ps

module sjf_schedule_monitor
   import sjf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_stall,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp_data,
   output int           error_count,
   output int           pending_results,
   output int           results_checked
);

   logic [TIME_BITS-1:0] job_burst   [MAX_PROCS];
   logic [TIME_BITS-1:0] job_arrival [MAX_PROCS];
   logic                 job_done    [MAX_PROCS];
   int                   jobs_loaded;
   logic                 dropped_seen;
   rsp_type              predicted_results [$];

   // shortest burst among arrived jobs, earlier arrival then lower index on ties
   function automatic int shortest_ready(input longint unsigned now);
      int best;
      int i;
      best = -1;
      for (i = 0; i < jobs_loaded; i++) begin
         if (!job_done[i] && job_arrival[i] <= now) begin
            if (best < 0 || job_burst[i] < job_burst[best] ||
                (job_burst[i] == job_burst[best] &&
                 job_arrival[i] < job_arrival[best]))
               best = i;
         end
      end
      return best;
   endfunction

   function automatic longint unsigned add_saturated(input longint unsigned acc,
                                                     input longint unsigned inc);
      longint unsigned sum;
      sum = acc + inc;
      return (sum > longint'(TOT_MAX)) ? longint'(TOT_MAX) : sum;
   endfunction

   task automatic load_and_schedule(input req_type rec);
      longint unsigned now, start, finish, waited, turned, soonest, tot_wait, tot_turn;
      int pick, k, i;
      rsp_type res;
      rsp_type run_results [$];
      if (jobs_loaded < MAX_PROCS) begin
         job_burst[jobs_loaded]   = rec.burst_time[TIME_BITS-1:0];
         job_arrival[jobs_loaded] = rec.arrival_time[TIME_BITS-1:0];
         job_done[jobs_loaded]    = 1'b0;
         jobs_loaded++;
      end else begin
         dropped_seen = 1'b1;
      end
      if (!rec.last_process) return;

      now = 0;
      tot_wait = 0;
      tot_turn = 0;
      for (k = 0; k < jobs_loaded; k++) begin
         pick = shortest_ready(now);
         if (pick < 0) begin
            // idle gap: jump to the earliest pending arrival
            soonest = 64'hFFFF_FFFF_FFFF_FFFF;
            for (i = 0; i < jobs_loaded; i++)
               if (!job_done[i] && job_arrival[i] < soonest)
                  soonest = 64'(job_arrival[i]);
            now = soonest;
            pick = shortest_ready(now);
            if (pick < 0) break;
         end
         start  = now;
         finish = start + 64'(job_burst[pick]);
         waited = start - 64'(job_arrival[pick]);
         turned = finish - 64'(job_arrival[pick]);
         now = finish;
         job_done[pick] = 1'b1;
         tot_wait = add_saturated(tot_wait, waited);
         tot_turn = add_saturated(tot_turn, turned);
         res = '0;
         res.process_index   = pick[3:0];
         res.waiting_time    = waited[19:0];
         res.turnaround_time = turned[19:0];
         res.completion_time = finish[20:0];
         res.overflow_flag   = dropped_seen;
         run_results.push_back(res);
      end
      if (run_results.size() > 0) begin
         res = run_results.pop_back();
         res.total_waiting    = tot_wait[23:0];
         res.total_turnaround = tot_turn[23:0];
         res.last_result      = 1'b1;
         run_results.push_back(res);
      end
      foreach (run_results[j]) predicted_results.push_back(run_results[j]);

      foreach (job_done[j]) job_done[j] = 1'b0;
      jobs_loaded  = 0;
      dropped_seen = 1'b0;
   endtask

   function automatic void compare_field(input string field, input longint unsigned want,
                                         input longint unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      end
   endfunction

   task automatic check_result(input rsp_type got);
      rsp_type want;
      results_checked++;
      if (predicted_results.size() == 0) begin
         error_count++;
         $display("%0t: result with nothing outstanding, expected none actual %h",
                  $time, got);
         return;
      end
      want = predicted_results.pop_front();
      compare_field("process_index", want.process_index, got.process_index);
      compare_field("waiting_time", want.waiting_time, got.waiting_time);
      compare_field("turnaround_time", want.turnaround_time, got.turnaround_time);
      compare_field("completion_time", want.completion_time, got.completion_time);
      compare_field("total_waiting", want.total_waiting, got.total_waiting);
      compare_field("total_turnaround", want.total_turnaround, got.total_turnaround);
      compare_field("overflow_flag", want.overflow_flag, got.overflow_flag);
      compare_field("last_result", want.last_result, got.last_result);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         jobs_loaded  = 0;
         dropped_seen = 1'b0;
         foreach (job_done[j]) job_done[j] = 1'b0;
         predicted_results.delete();
         error_count     = 0;
         results_checked = 0;
         pending_results <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
         if (req_valid && !req_stall) load_and_schedule(req_data);
         pending_results <= predicted_results.size();
      end
   end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import sjf_pkg::*;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   int error_count;
   int pending_results;
   int results_checked;

   int   records_sent   = 0;
   int   sets_sent      = 0;
   int   overfull_sets  = 0;
   int   random_records = 0;
   bit   sender_idles   = 1'b1;
   int   stall_odds     = 4;
   int   stall_run      = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sjf_nonpreemptive_scheduler_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   sjf_schedule_monitor run_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .error_count     (error_count),
      .pending_results (pending_results),
      .results_checked (results_checked)
   );

   // receiver back-pressure in bursts; stall_odds of zero means none
   always @(posedge clock) begin
      if (reset || stall_odds == 0) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (stall_run != 0) begin
         stall_run <= stall_run - 1;
         if (stall_run == 1) rsp_stall <= 1'b0;
      end else if ($urandom_range(1, stall_odds) == 1) begin
         rsp_stall <= 1'b1;
         stall_run <= $urandom_range(1, 17);
      end
   end

   task automatic send_record(input logic [15:0] burst, input logic [15:0] arrival,
                              input logic last);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{burst_time: burst, arrival_time: arrival, last_process: last};
      do @(posedge clock); while (req_stall);
      records_sent++;
      if (last) sets_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   task automatic send_random_set();
      int style, mode, count, k;
      logic [15:0] burst, arrival;
      style = $urandom_range(0, 9);
      mode  = $urandom_range(0, 2);
      if (style == 0) count = $urandom_range(MAX_PROCS + 1, MAX_PROCS + 4);
      else if (style < 3) count = $urandom_range(1, 4);
      else count = $urandom_range(2, MAX_PROCS);
      if (count > MAX_PROCS) overfull_sets++;
      for (k = 0; k < count; k++) begin
         case (mode)
            0: begin
               // crowded start, many ties
               burst   = 16'($urandom_range(0, 7));
               arrival = 16'($urandom_range(0, 10));
            end
            1: begin
               burst   = 16'($urandom);
               arrival = 16'($urandom);
            end
            default: begin
               // short jobs spread out, so the clock has to skip idle gaps
               burst   = 16'($urandom_range(0, 50));
               arrival = 16'($urandom);
            end
         endcase
         send_record(burst, arrival, k == count - 1);
         random_records++;
      end
   endtask

   initial begin
      int k;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // lone zero-length job
      send_record(16'd0, 16'd0, 1'b1);
      // nothing ready at time zero, then a long idle gap before the full-scale job
      send_record(16'd3, 16'd10, 1'b0);
      send_record(16'hFFFF, 16'hFFFF, 1'b0);
      send_record(16'd1, 16'd10, 1'b1);
      // equal bursts: earlier arrival first, then lower index
      send_record(16'd4, 16'd0, 1'b0);
      send_record(16'd5, 16'd2, 1'b0);
      send_record(16'd5, 16'd1, 1'b0);
      send_record(16'd5, 16'd1, 1'b1);
      // full store, and the marked record itself gets dropped
      for (k = 0; k <= MAX_PROCS; k++)
         send_record(16'(k * 4099), 16'(k * 3), k == MAX_PROCS);
      overfull_sets++;
      wait_drained();

      while (random_records < 95) begin
         if (random_records >= 75) begin
            sender_idles = 1'b0;
            stall_odds  <= 0;
         end else begin
            sender_idles = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 3))
               0:       stall_odds <= 0;
               1:       stall_odds <= 2;
               default: stall_odds <= 8;
            endcase
         end
         send_random_set();
         if ($urandom_range(0, 4) == 0) wait_drained();
      end

      wait_drained();
      repeat (60) @(posedge clock);
      $display("summary: %0d records in %0d scheduled sets (%0d overfilling the store)",
               records_sent, sets_sent, overfull_sets);
      $display("summary: %0d results compared", results_checked);
      if (error_count == 0 && pending_results == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d results outstanding", pending_results);
      $display("testbench: errors");
      $finish;
   end

endmodule
